[hw/rtl/oli_pkg.sv]
// ----------------------------------------------------------------------------
// oli_pkg : shared types and codes for the ordered list
// Request and result beat layouts, operation and status codes, cell control.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int ELEMENT_BITS_DEF = 32;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_DELETE = 3'd1,
    FN_GET    = 3'd2,
    FN_LOCATE = 3'd3,
    FN_LENGTH = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  position;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [6:0]  found_position;
    logic [6:0]  count;
  } out_t;

  // Broadcast to every cell
  typedef struct packed {
    logic ins;       // insert: open a gap at p0 and load the new element
    logic del;       // delete: close the gap at p0
    logic scan_get;  // scan matches on index (get) rather than on value (locate)
  } cell_ctl_t;

  // Flags of the search token walking down the chain
  typedef struct packed {
    logic valid;
    logic found;
  } tok_flag_t;

endpackage

[hw/rtl/ordered_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_delete : fixed-capacity positional list
// Row of element cells with shift-up/shift-down and a travelling search token.
// ----------------------------------------------------------------------------
// Usage
//  - Request beat: in_data (func, position, value) is taken at a rising edge
//    with start high and busy low. Positions are 1-based.
//  - Result beat: out_data is shown for exactly one cycle with out_valid high.
//    The receiver cannot stall; a result that is not taken is lost.
//  - Insert, delete, length and any rejected request: the cells shift in the
//    accept cycle, the result appears in the next cycle and busy stays low,
//    so these ops run one per cycle.
//  - Get (in range) and locate: a search token walks the chain of cells,
//    one cell per cycle, picking up the first hit. Busy is high from the
//    accept edge until the token leaves the last cell; the result is then
//    registered from the token, so the search time grows with the chain.
//  - Unknown func codes answer bad position and change nothing.
//  - Reset (rst_n low, synchronous) empties the list and drops any search
//    in flight. Element storage is not cleared; only positions below the
//    count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete #(
  parameter int CAPACITY     = oli_pkg::CAPACITY_DEF,
  parameter int ELEMENT_BITS = oli_pkg::ELEMENT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  oli_pkg::in_t in_data,
  output logic         out_valid,
  output oli_pkg::out_t out_data
);
  import oli_pkg::*;

  // index/count width, and a compare width wide enough for both the
  // 7-bit position field and the count
  localparam int IW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((IW > 7) ? IW : 7) + 1;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                  state_r;
  logic [IW-1:0]           count_r;
  logic                    start_r;       // inject token into the first cell
  logic                    q_get_r;       // scan is a get (else locate)
  logic [IW-1:0]           q_p0_r;
  logic [ELEMENT_BITS-1:0] q_key_r;
  logic                    out_valid_r;
  out_t                    out_r;

  logic                    accept;
  logic [CMP_W-1:0]        pos_c, len_c;
  logic [IW-1:0]           p0_c;
  logic [ELEMENT_BITS-1:0] val_c;
  status_t                 status_c;
  logic [IW-1:0]           count_nxt;
  logic                    do_ins, do_del, do_scan, scan_get_c;
  cell_ctl_t               ctl;
  logic [IW-1:0]           cell_p0;

  // chain wiring
  logic [ELEMENT_BITS-1:0] elem_w [0:CAPACITY-1];
  tok_flag_t               tk_f   [0:CAPACITY];
  logic [IW-1:0]           tk_pos [0:CAPACITY];
  logic [ELEMENT_BITS-1:0] tk_dat [0:CAPACITY];

  assign accept = start && !busy;
  assign busy   = (state_r == S_SCAN);

  assign pos_c = CMP_W'(in_data.position);
  assign len_c = CMP_W'(count_r);
  assign p0_c  = IW'(pos_c - CMP_W'(1));
  assign val_c = ELEMENT_BITS'(in_data.value);

  // request decode: status and what the cells must do
  always_comb begin
    status_c   = ST_OK;
    count_nxt  = count_r;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    do_scan    = 1'b0;
    scan_get_c = 1'b0;
    unique case (in_data.func)
      FN_INSERT: begin
        if (pos_c == '0 || pos_c > len_c + CMP_W'(1)) begin
          status_c = ST_BADPOS;
        end else if (len_c == CMP_W'(CAPACITY)) begin
          status_c = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + IW'(1);
        end
      end
      FN_DELETE: begin
        if (count_r == '0) begin
          status_c = ST_EMPTY;
        end else if (pos_c == '0 || pos_c > len_c) begin
          status_c = ST_BADPOS;
        end else begin
          do_del    = 1'b1;
          count_nxt = count_r - IW'(1);
        end
      end
      FN_GET: begin
        if (count_r == '0) begin
          status_c = ST_EMPTY;
        end else if (pos_c == '0 || pos_c > len_c) begin
          status_c = ST_BADPOS;
        end else begin
          do_scan    = 1'b1;
          scan_get_c = 1'b1;
        end
      end
      FN_LOCATE: begin
        do_scan = 1'b1;
      end
      FN_LENGTH: begin
        status_c = ST_OK;
      end
      default: begin
        status_c = ST_BADPOS;
      end
    endcase
  end

  // the shift uses the live request; the search uses the latched query
  always_comb begin
    ctl.ins      = accept && do_ins;
    ctl.del      = accept && do_del;
    ctl.scan_get = q_get_r;
    cell_p0      = (ctl.ins || ctl.del) ? p0_c : q_p0_r;
  end

  assign tk_f[0].valid = start_r;
  assign tk_f[0].found = 1'b0;
  assign tk_pos[0]     = '0;
  assign tk_dat[0]     = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left_e, right_e;
    // end cells see themselves; their shift arm never selects it usefully
    assign left_e  = (i == 0) ? elem_w[i] : elem_w[(i == 0) ? 0 : i - 1];
    assign right_e = (i == CAPACITY - 1) ? elem_w[i]
                                         : elem_w[(i == CAPACITY - 1) ? i : i + 1];

    oli_cell #(
      .IDX          (i),
      .IW           (IW),
      .ELEMENT_BITS (ELEMENT_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .p0          (cell_p0),
      .ins_value   (val_c),
      .q_len       (count_r),
      .q_key       (q_key_r),
      .left_elem   (left_e),
      .right_elem  (right_e),
      .elem        (elem_w[i]),
      .tok_in_f    (tk_f[i]),
      .tok_in_pos  (tk_pos[i]),
      .tok_in_dat  (tk_dat[i]),
      .tok_out_f   (tk_f[i+1]),
      .tok_out_pos (tk_pos[i+1]),
      .tok_out_dat (tk_dat[i+1])
    );
  end

  // control, query latch and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      q_get_r     <= 1'b0;
      q_p0_r      <= '0;
      q_key_r     <= '0;
      out_r       <= '0;
    end else begin
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            count_r <= count_nxt;
            if (do_scan) begin
              state_r <= S_SCAN;
              start_r <= 1'b1;
              q_get_r <= scan_get_c;
              q_p0_r  <= p0_c;
              q_key_r <= val_c;
            end else begin
              out_valid_r          <= 1'b1;
              out_r.status         <= status_c;
              out_r.data           <= '0;
              out_r.found_position <= '0;
              out_r.count          <= 7'(count_nxt);
            end
          end
        end
        S_SCAN: begin
          if (tk_f[CAPACITY].valid) begin
            state_r              <= S_IDLE;
            out_valid_r          <= 1'b1;
            out_r.status         <= ST_OK;
            out_r.count          <= 7'(count_r);
            if (q_get_r) begin
              out_r.data           <= 32'(tk_dat[CAPACITY]);
              out_r.found_position <= '0;
            end else begin
              out_r.data           <= '0;
              out_r.found_position <= tk_f[CAPACITY].found ? 7'(tk_pos[CAPACITY]) : 7'd0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_scan_ends_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("search finished without a result beat");

  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("accepted request neither answered nor searching");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IW'(CAPACITY))
    else $error("list count beyond capacity");

  a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> busy)
    else $error("search token launched outside a search");
`endif

endmodule

[hw/rtl/oli_cell.sv]
// ----------------------------------------------------------------------------
// oli_cell : one list slot
// Holds one element, shifts with its neighbours and passes the search token on.
// ----------------------------------------------------------------------------
module oli_cell #(
  parameter int IDX          = 0,
  parameter int IW           = 7,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  oli_pkg::cell_ctl_t      ctl,
  input  logic [IW-1:0]           p0,
  input  logic [ELEMENT_BITS-1:0] ins_value,
  input  logic [IW-1:0]           q_len,
  input  logic [ELEMENT_BITS-1:0] q_key,
  input  logic [ELEMENT_BITS-1:0] left_elem,
  input  logic [ELEMENT_BITS-1:0] right_elem,
  output logic [ELEMENT_BITS-1:0] elem,
  input  oli_pkg::tok_flag_t      tok_in_f,
  input  logic [IW-1:0]           tok_in_pos,
  input  logic [ELEMENT_BITS-1:0] tok_in_dat,
  output oli_pkg::tok_flag_t      tok_out_f,
  output logic [IW-1:0]           tok_out_pos,
  output logic [ELEMENT_BITS-1:0] tok_out_dat
);
  import oli_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [IW-1:0] MY_POS = IW'(IDX + 1);

  logic [ELEMENT_BITS-1:0] elem_r, elem_nxt;
  tok_flag_t               tok_f_r, tok_f_nxt;
  logic [IW-1:0]           tok_pos_r, tok_pos_nxt;
  logic [ELEMENT_BITS-1:0] tok_dat_r, tok_dat_nxt;
  logic                    hit;

  always_comb begin
    elem_nxt = elem_r;
    if (ctl.ins && MY_IDX == p0) begin
      elem_nxt = ins_value;
    end else if (ctl.ins && MY_IDX > p0) begin
      elem_nxt = left_elem;
    end else if (ctl.del && MY_IDX >= p0) begin
      elem_nxt = right_elem;
    end
  end

  assign hit = ctl.scan_get ? (MY_IDX == p0) : ((elem_r == q_key) && (MY_IDX < q_len));

  always_comb begin
    tok_f_nxt   = tok_in_f;
    tok_pos_nxt = tok_in_pos;
    tok_dat_nxt = tok_in_dat;
    // first hit along the chain wins
    if (tok_in_f.valid && !tok_in_f.found && hit) begin
      tok_f_nxt.found = 1'b1;
      tok_pos_nxt     = MY_POS;
      tok_dat_nxt     = elem_r;
    end
  end

  always_ff @(posedge clk) begin
    elem_r      <= elem_nxt;
    tok_pos_r   <= tok_pos_nxt;
    tok_dat_r   <= tok_dat_nxt;
    if (!rst_n) begin
      tok_f_r <= '0;
    end else begin
      tok_f_r <= tok_f_nxt;
    end
  end

  assign elem        = elem_r;
  assign tok_out_f   = tok_f_r;
  assign tok_out_pos = tok_pos_r;
  assign tok_out_dat = tok_dat_r;

endmodule

[tb/sv/ordered_list_insert_delete_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_tb : self-checking bench for the positional list
// Drives insert, delete, get, locate and length requests, keeps a shadow copy
// of the list and checks every result beat field by field against it.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_tb;
  import oli_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int IN_W         = $bits(in_t);
  localparam int STALL_LIMIT  = 1000;   // cycles with no beat in either direction
  localparam int PHASE_ITEMS  = 185;
  localparam int BIAS_SPAN    = 160;    // items per grow / shrink stretch

  // func codes the block does not define; they must be answered as bad position
  localparam logic [2:0] FN_UNDEF_A = 3'd5;
  localparam logic [2:0] FN_UNDEF_B = 3'd6;
  localparam logic [2:0] FN_UNDEF_C = 3'd7;

  // --------------------------------------------------------------------------
  // Shadow list and result check
  // --------------------------------------------------------------------------
  class list_checker;
    logic [31:0] elems [CAP];
    int          len;
    int          peak_len;
    out_t        pending [$];
    int          fails;
    int          n_requests;
    int          n_checked;
    int          status_seen [4];

    // Works out the result of an accepted request beat and updates the shadow.
    function void note_request(in_t req);
      out_t exp;
      int   p;
      int   j;
      exp        = '0;
      exp.status = ST_OK;
      p          = int'(req.position);
      case (req.func)
        FN_INSERT: begin
          if (p < 1 || p > len + 1) begin
            exp.status = ST_BADPOS;
          end else if (len >= CAP) begin
            exp.status = ST_FULL;
          end else begin
            for (j = len; j >= p; j--) elems[j] = elems[j - 1];
            elems[p - 1] = req.value;
            len++;
          end
        end
        FN_DELETE: begin
          if (len == 0) begin
            exp.status = ST_EMPTY;
          end else if (p < 1 || p > len) begin
            exp.status = ST_BADPOS;
          end else begin
            for (j = p; j < len; j++) elems[j - 1] = elems[j];
            len--;
          end
        end
        FN_GET: begin
          if (len == 0) begin
            exp.status = ST_EMPTY;
          end else if (p < 1 || p > len) begin
            exp.status = ST_BADPOS;
          end else begin
            exp.data = elems[p - 1];
          end
        end
        FN_LOCATE: begin
          // first match wins; an empty list simply finds nothing
          for (j = 0; j < len; j++) begin
            if (elems[j] == req.value) begin
              exp.found_position = 7'(j + 1);
              break;
            end
          end
        end
        FN_LENGTH: begin
        end
        default: begin
          exp.status = ST_BADPOS;
        end
      endcase
      exp.count = 7'(len);
      if (len > peak_len) peak_len = len;
      n_requests++;
      pending.push_back(exp);
    endfunction

    // Compares a result beat with the oldest outstanding expectation.
    function void check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result beat: status %0d data %h found %0d count %0d",
               got.status, got.data, got.found_position, got.count);
        fails++;
        return;
      end
      exp = pending.pop_front();
      n_checked++;
      status_seen[exp.status]++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        fails++;
      end
      if (got.data !== exp.data) begin
        $error("data: expected %h, actual %h", exp.data, got.data);
        fails++;
      end
      if (got.found_position !== exp.found_position) begin
        $error("found_position: expected %0d, actual %0d",
               exp.found_position, got.found_position);
        fails++;
      end
      if (got.count !== exp.count) begin
        $error("count: expected %0d, actual %0d", exp.count, got.count);
        fails++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, block
  // --------------------------------------------------------------------------
  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  list_checker sb = new();
  int          quiet_cycles = 0;

  always #10 clk = ~clk;

  ordered_list_insert_delete dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Result beats can't be held off, so every strobe is checked as it comes.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // Watchdog: a cycle moving no beat either way counts towards the limit.
  // The longest honest silence is a search plus a sender gap.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_t mk(logic [2:0] fn, int pos, logic [31:0] val);
    in_t req;
    req.func     = fn;
    req.position = 7'(pos);
    req.value    = val;
    return req;
  endfunction

  // Presents one request beat and returns once it has been taken. The sender
  // idles at random first; in_data carries junk while start is low.
  task automatic send(in_t req, int idle_pct);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= in_t'(IN_W'({$urandom, $urandom}));
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
  endtask

  // Mostly well-formed requests against the current shadow length, with a
  // bias towards growing or shrinking so that both full and empty get hit.
  function automatic in_t rand_request(bit grow);
    in_t req;
    int  r;
    int  n;
    int  ins_hi;
    n      = sb.len;
    r      = $urandom_range(99);
    ins_hi = grow ? 62 : 17;
    case ($urandom_range(7))
      0:       req.value = '0;
      1:       req.value = '1;
      2, 3:    req.value = $urandom_range(15);   // small pool: duplicates
      default: req.value = $urandom;
    endcase
    if (r < 2) begin
      req.func = 3'(FN_UNDEF_A + $urandom_range(2));
    end else if (r < ins_hi) begin
      req.func = FN_INSERT;
    end else if (r < 72) begin
      req.func = FN_DELETE;
    end else if (r < 84) begin
      req.func = FN_GET;
    end else if (r < 96) begin
      req.func = FN_LOCATE;
      if (n > 0 && $urandom_range(9) < 6) req.value = sb.elems[$urandom_range(n - 1)];
    end else begin
      req.func = FN_LENGTH;
    end
    // one in ten positions is arbitrary, the rest valid for the current length
    if ($urandom_range(9) == 0) begin
      req.position = 7'($urandom_range(CAP));
    end else if (req.func == FN_INSERT) begin
      req.position = 7'($urandom_range((n < CAP) ? n + 1 : CAP, 1));
    end else if (n > 0) begin
      req.position = 7'($urandom_range(n, 1));
    end else begin
      req.position = 7'($urandom_range(CAP));
    end
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int   idle_pct [4];
    int   k;
    in_t  directed [$];
    idle_pct = '{0, 48, 0, 12};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, edge positions, front/middle/end insert, hits and misses
    directed = '{
      mk(FN_LENGTH, 0, '0),
      mk(FN_DELETE, 1, '0),
      mk(FN_GET, 1, '0),
      mk(FN_LOCATE, 0, '0),
      mk(FN_INSERT, 0, 32'h1111_1111),
      mk(FN_INSERT, 2, 32'h2222_2222),
      mk(FN_INSERT, 1, 32'hFFFF_FFFF),
      mk(FN_INSERT, 1, 32'h0000_0000),
      mk(FN_INSERT, 3, 32'hA5A5_A5A5),
      mk(FN_INSERT, 2, 32'h5A5A_5A5A),
      mk(FN_GET, 0, '0),
      mk(FN_GET, 5, '0),
      mk(FN_GET, 1, '0),
      mk(FN_GET, 4, '0),
      mk(FN_LOCATE, 0, 32'hFFFF_FFFF),
      mk(FN_LOCATE, 0, 32'h1234_5678),
      mk(FN_DELETE, 0, '0),
      mk(FN_DELETE, 5, '0),
      mk(FN_DELETE, 2, '0),
      mk(FN_DELETE, 3, '0),
      mk(FN_UNDEF_A, 64, 32'hFFFF_FFFF),
      mk(FN_UNDEF_B, 1, '0),
      mk(FN_UNDEF_C, 127, 32'h8000_0001),
      mk(FN_GET, 64, '0),
      mk(FN_LENGTH, 64, '1)
    };
    foreach (directed[i]) send(directed[i], 0);

    // random stretches under each sender idling pattern
    k = 0;
    foreach (idle_pct[ph]) begin
      repeat (PHASE_ITEMS) begin
        send(rand_request(((k / BIAS_SPAN) % 2) == 0), idle_pct[ph]);
        k++;
      end
    end
    start <= 1'b0;

    // drain, then leave room for a late search result or a stray beat
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (CAP + 4) @(posedge clk);

    $display("%0d requests sent, %0d results checked; peak length %0d of %0d",
             sb.n_requests, sb.n_checked, sb.peak_len, CAP);
    $display("statuses seen ok %0d, bad position %0d, empty %0d, full %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_BADPOS],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL]);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/oli_pkg.sv
hw/rtl/oli_cell.sv
hw/rtl/ordered_list_insert_delete.sv
tb/sv/ordered_list_insert_delete_tb.sv
